FILE: hw/rtl/qas_pkg.sv
package qas_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS  = 1'd1;

    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 5;

    localparam logic [7:0] DELIM_RESET    = 8'h2C;
    localparam logic [4:0] MAX_ARGS_RESET = 5'd16;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

    // Bit 2 flags a pending escape
    typedef enum logic [2:0] {
        MODE_DELIM      = 3'd0,
        MODE_ARG        = 3'd1,
        MODE_QUOTED     = 3'd2,
        MODE_ARG_ESC    = 3'd5,
        MODE_QUOTED_ESC = 3'd6
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] count;
    } ctl_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic               out_valid;
        logic [7:0]         out_byte;
        logic [7:0]         out_pos;
        logic               arg_start;
        logic               arg_end;
        logic [COUNT_W-1:0] arg_total;
        logic               line_done;
    } out_t;

endpackage

FILE: hw/rtl/qas_step.sv
module qas_step import qas_pkg::*; #(
    parameter int MAX_ARGS   = 16,
    parameter int LINE_BYTES = 256,
    parameter int POS_W      = $clog2(LINE_BYTES)
) (
    input  in_t              item,
    input  ctl_t             ctl,
    input  logic [POS_W-1:0] pos,
    input  logic [7:0]       delimiter,
    input  logic [4:0]       max_args,
    output out_t             res,
    output ctl_t             ctl_next,
    output logic [POS_W-1:0] pos_next
);

    logic [POS_W+7:0] pos_ext;
    logic             room;
    logic             pos_full;
    logic             wr;
    logic             st;
    logic             en;
    logic [7:0]       byte_out;
    logic [7:0]       c;

    assign pos_ext  = {8'd0, pos};
    assign room     = (ctl.count < max_args) && (32'(ctl.count) < MAX_ARGS);
    assign pos_full = 32'(pos) >= (LINE_BYTES - 1);
    assign c        = item.char_in;

    always_comb begin
        ctl_next = ctl;
        pos_next = pos;
        wr       = 1'b0;
        st       = 1'b0;
        en       = 1'b0;
        byte_out = 8'd0;

        if (item.line_end) begin
            // Final zero goes out unconditionally; count an open argument if there is room
            wr = 1'b1;
            if (ctl.mode != MODE_DELIM && room) begin
                en             = 1'b1;
                ctl_next.count = ctl.count + 5'd1;
            end
        end else if (room) begin
            case (ctl.mode)
                MODE_ARG, MODE_QUOTED: begin
                    if ((ctl.mode == MODE_ARG && c == delimiter) ||
                        (ctl.mode == MODE_QUOTED && c == QUOTE_BYTE)) begin
                        en = 1'b1;
                        wr = 1'b1;
                    end else if (c == ESCAPE_BYTE) begin
                        ctl_next.mode = (ctl.mode == MODE_ARG) ? MODE_ARG_ESC
                                                               : MODE_QUOTED_ESC;
                    end else begin
                        wr       = 1'b1;
                        byte_out = c;
                    end
                end
                MODE_ARG_ESC, MODE_QUOTED_ESC: begin
                    // Keep only escaped quote, backslash or delimiter
                    if (c == ESCAPE_BYTE || c == QUOTE_BYTE || c == delimiter) begin
                        wr       = 1'b1;
                        byte_out = c;
                    end
                    ctl_next.mode = (ctl.mode == MODE_ARG_ESC) ? MODE_ARG : MODE_QUOTED;
                end
                default: begin
                    if (c == delimiter) begin
                        ctl_next.mode = MODE_DELIM;
                    end else if (c == QUOTE_BYTE) begin
                        st            = 1'b1;
                        ctl_next.mode = MODE_QUOTED;
                    end else if (c == ESCAPE_BYTE) begin
                        st            = 1'b1;
                        ctl_next.mode = MODE_ARG_ESC;
                    end else begin
                        st            = 1'b1;
                        ctl_next.mode = MODE_ARG;
                        wr            = 1'b1;
                        byte_out      = c;
                    end
                end
            endcase
            if (en) begin
                ctl_next.count = ctl.count + 5'd1;
                ctl_next.mode  = MODE_DELIM;
            end
            // Drop writes that would land in the last buffer slot or beyond
            if (wr) begin
                if (pos_full) begin
                    wr       = 1'b0;
                    byte_out = 8'd0;
                end else begin
                    pos_next = pos + POS_W'(1);
                end
            end
        end

        res.out_valid = wr;
        res.out_byte  = byte_out;
        res.out_pos   = pos_ext[7:0];
        res.arg_start = st;
        res.arg_end   = en;
        res.arg_total = ctl_next.count;
        res.line_done = item.line_end;

        if (item.line_end) begin
            ctl_next.mode  = MODE_DELIM;
            ctl_next.count = '0;
            pos_next       = '0;
        end
    end

endmodule

FILE: hw/rtl/quoted_argument_splitter.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_data  (in_t: char_in, line_end)
// m_        out  m_valid / m_ready  m_data  (out_t: one result per request)
// cfg_      in   cfg_we             cfg_index, cfg_wdata (delimiter, max_args)
//
// Each request goes from acceptance into the input register, then through the
// parse step into the result register. One request is accepted every cycle
// unless m_ready stalls; the parse state loop is a single step.
// Reset (aresetn low, synchronous) empties both stages, clears the parse state
// and loads delimiter ',' and max_args 16.
// A stalled m_ready holds the result register; the input register still takes
// a request if the result register frees in the same cycle.
module quoted_argument_splitter import qas_pkg::*; #(
    parameter int MAX_ARGS   = 16,
    parameter int LINE_BYTES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int POS_W = $clog2(LINE_BYTES);

    // Input stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    in_t              s1_data_reg;

    // Result stage
    logic             m_valid_reg;
    logic             m_valid_next;
    out_t             m_data_reg;

    // Parse state
    ctl_t             ctl_reg;
    ctl_t             ctl_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    // Configuration
    logic [7:0]       delim_reg;
    logic [4:0]       max_args_reg;

    out_t             step_res;
    logic             out_free;
    logic             s1_adv;
    logic             s_acc;

    // Result register frees when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_acc    = s_valid && s_ready;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    qas_step #(
        .MAX_ARGS   (MAX_ARGS),
        .LINE_BYTES (LINE_BYTES),
        .POS_W      (POS_W)
    ) u_step (
        .item      (s1_data_reg),
        .ctl       (ctl_reg),
        .pos       (pos_reg),
        .delimiter (delim_reg),
        .max_args  (max_args_reg),
        .res       (step_res),
        .ctl_next  (ctl_next),
        .pos_next  (pos_next)
    );

    always_comb begin
        // Fill on acceptance, drain when the request moves on
        if (s_acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ctl_reg      <= '{mode: MODE_DELIM, count: '0};
            pos_reg      <= '0;
            delim_reg    <= DELIM_RESET;
            max_args_reg <= MAX_ARGS_RESET;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            // Advance the parse state only when a request leaves the input stage
            if (s1_adv) begin
                ctl_reg <= ctl_next;
                pos_reg <= pos_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_DELIMITER: delim_reg    <= cfg_wdata;
                    REG_MAX_ARGS:  max_args_reg <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_data_reg <= s_data;
        end
        if (s1_adv) begin
            m_data_reg <= step_res;
        end
    end

    // Line end clears the parse state for the next line
    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_data_reg.line_end) |=>
        (ctl_reg.mode == MODE_DELIM && ctl_reg.count == '0 && pos_reg == '0))
        else $error("parse state not cleared after line end");

    // A written byte advances the write position by one
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && step_res.out_valid && !step_res.line_done) |=>
        (pos_reg == $past(pos_reg) + POS_W'(1)))
        else $error("write position did not advance");

    // An argument cannot start and end on the same byte
    a_start_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.arg_start && m_data_reg.arg_end))
        else $error("argument start and end on one request");

    // Line end always writes a zero terminator
    a_final_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.line_done) |->
        (m_data_reg.out_valid && m_data_reg.out_byte == 8'd0))
        else $error("line end without final zero");

endmodule

FILE: bench/quoted_argument_splitter_test.sv
`timescale 1ns / 1ps

module quoted_argument_splitter_test;
    import qas_pkg::*;

    localparam int ARG_CAP         = 16;
    localparam int LINE_SIZE       = 256;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 10;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DELIMITER;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    quoted_argument_splitter #(
        .MAX_ARGS   (ARG_CAP),
        .LINE_BYTES (LINE_SIZE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Byte requests waiting to be offered, and split results predicted for
    // requests already taken by the block, oldest first.
    in_t  byte_requests[$];
    out_t predicted_splits[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int bad_results  = 0;
    int phase_bytes  = 0;
    int quiet_cycles = 0;

    // Shadow of the configuration registers, kept in step with every write.
    logic [7:0] delim_cfg    = DELIM_RESET;
    logic [4:0] max_args_cfg = MAX_ARGS_RESET;

    // Shadow of the parse state: mode, arguments counted, next write slot.
    mode_t      split_state = MODE_DELIM;
    logic [4:0] arg_count   = '0;
    int         write_slot  = 0;

    // Advance the shadow parser by one request and produce its result.
    task automatic split_step(input in_t req, output out_t res);
        int         cap;
        logic       wr, st, en;
        logic [7:0] b;
        logic [7:0] c;
        int         pos;
        cap = (max_args_cfg < ARG_CAP) ? max_args_cfg : ARG_CAP;
        pos = write_slot;
        c   = req.char_in;
        wr  = 1'b0;
        st  = 1'b0;
        en  = 1'b0;
        b   = 8'h00;
        if (req.line_end) begin
            // The final zero always goes out; an open argument counts if room.
            wr = 1'b1;
            if (split_state != MODE_DELIM && arg_count < cap) begin
                en = 1'b1;
                arg_count = arg_count + 1'b1;
            end
        end else if (arg_count < cap) begin
            case (split_state)
                MODE_ARG: begin
                    if (c == delim_cfg) begin
                        en = 1'b1;
                        wr = 1'b1;
                    end else if (c == ESCAPE_BYTE) begin
                        split_state = MODE_ARG_ESC;
                    end else begin
                        wr = 1'b1;
                        b  = c;
                    end
                end
                MODE_QUOTED: begin
                    if (c == QUOTE_BYTE) begin
                        en = 1'b1;
                        wr = 1'b1;
                    end else if (c == ESCAPE_BYTE) begin
                        split_state = MODE_QUOTED_ESC;
                    end else begin
                        wr = 1'b1;
                        b  = c;
                    end
                end
                MODE_ARG_ESC, MODE_QUOTED_ESC: begin
                    // Keep quote, backslash and delimiter; drop anything else.
                    if (c == ESCAPE_BYTE || c == QUOTE_BYTE || c == delim_cfg) begin
                        wr = 1'b1;
                        b  = c;
                    end
                    if (split_state == MODE_ARG_ESC) begin
                        split_state = MODE_ARG;
                    end else begin
                        split_state = MODE_QUOTED;
                    end
                end
                default: begin
                    if (c == delim_cfg) begin
                        split_state = MODE_DELIM;
                    end else if (c == QUOTE_BYTE) begin
                        st = 1'b1;
                        split_state = MODE_QUOTED;
                    end else if (c == ESCAPE_BYTE) begin
                        st = 1'b1;
                        split_state = MODE_ARG_ESC;
                    end else begin
                        st = 1'b1;
                        split_state = MODE_ARG;
                        wr = 1'b1;
                        b  = c;
                    end
                end
            endcase
            if (en) begin
                arg_count = arg_count + 1'b1;
                split_state = MODE_DELIM;
            end
            // Drop writes that would land in the last slot of the line buffer.
            if (wr) begin
                if (pos >= LINE_SIZE - 1) begin
                    wr = 1'b0;
                    b  = 8'h00;
                end else begin
                    write_slot = pos + 1;
                end
            end
        end
        res.out_valid = wr;
        res.out_byte  = b;
        res.out_pos   = pos[7:0];
        res.arg_start = st;
        res.arg_end   = en;
        res.arg_total = arg_count;
        res.line_done = req.line_end;
        if (req.line_end) begin
            split_state = MODE_DELIM;
            arg_count   = '0;
            write_slot  = 0;
        end
    endtask

    // Driver: predict each accepted request, then offer the next one unless
    // the sender idles this cycle. Hold valid and payload until accepted.
    always @(posedge aclk) begin : drive_requests
        out_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                split_step(s_data, predicted);
                predicted_splits.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (byte_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= byte_requests.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction,
    // then pick the next cycle's ready.
    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_splits.size() == 0) begin
                bad_results = bad_results + 1;
                if (bad_results <= MAX_REPORTS) begin
                    $display("unexpected result: valid=%0d byte=%02h pos=%0d ",
                             m_data.out_valid, m_data.out_byte, m_data.out_pos,
                             "start=%0d end=%0d total=%0d done=%0d",
                             m_data.arg_start, m_data.arg_end, m_data.arg_total,
                             m_data.line_done);
                end
            end else begin
                want = predicted_splits.pop_front();
                if (m_data.out_valid !== want.out_valid || m_data.out_byte !== want.out_byte ||
                    m_data.out_pos !== want.out_pos || m_data.arg_start !== want.arg_start ||
                    m_data.arg_end !== want.arg_end || m_data.arg_total !== want.arg_total ||
                    m_data.line_done !== want.line_done) begin
                    bad_results = bad_results + 1;
                    if (bad_results <= MAX_REPORTS) begin
                        $display("mismatch exp: valid=%0d byte=%02h pos=%0d ",
                                 want.out_valid, want.out_byte, want.out_pos,
                                 "start=%0d end=%0d total=%0d done=%0d",
                                 want.arg_start, want.arg_end, want.arg_total,
                                 want.line_done);
                        $display("         got: valid=%0d byte=%02h pos=%0d ",
                                 m_data.out_valid, m_data.out_byte, m_data.out_pos,
                                 "start=%0d end=%0d total=%0d done=%0d",
                                 m_data.arg_start, m_data.arg_end, m_data.arg_total,
                                 m_data.line_done);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("quoted_argument_splitter regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] c);
        in_t req;
        req.char_in  = c;
        req.line_end = 1'b0;
        byte_requests.push_back(req);
        phase_bytes = phase_bytes + 1;
    endtask

    // The byte under a line end is ignored, so fill it with noise.
    task automatic push_line_end();
        in_t req;
        req.char_in  = 8'($urandom_range(0, 255));
        req.line_end = 1'b1;
        byte_requests.push_back(req);
        phase_bytes = phase_bytes + 1;
    endtask

    // Any byte that is neither delimiter, quote nor backslash.
    function automatic logic [7:0] plain_byte(input logic [7:0] d);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == d || c == QUOTE_BYTE || c == ESCAPE_BYTE) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_byte(input logic [7:0] d);
        case ($urandom_range(0, 5))
            0:       return QUOTE_BYTE;
            1:       return ESCAPE_BYTE;
            2:       return d;
            3:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Backslash followed by a kept byte most of the time, a dropped one else.
    task automatic push_escape(input logic [7:0] d);
        push_byte(ESCAPE_BYTE);
        case ($urandom_range(0, 3))
            0:       push_byte(QUOTE_BYTE);
            1:       push_byte(ESCAPE_BYTE);
            2:       push_byte(d);
            default: push_byte(plain_byte(d));
        endcase
    endtask

    task automatic push_body(input logic [7:0] d);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) begin
                push_escape(d);
            end else begin
                push_byte(plain_byte(d));
            end
        end
    endtask

    // One line: mostly well-formed arguments with random content, sometimes
    // enough of them to hit the limit, sometimes plain noise.
    task automatic push_line(input logic [7:0] d);
        int n_args;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 12)) push_byte(noise_byte(d));
        end else begin
            n_args = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
            for (int i = 0; i < n_args; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_byte(d);
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(QUOTE_BYTE);
                    push_body(d);
                    // Leave a quote open now and then.
                    if ($urandom_range(0, 9) != 0) begin
                        push_byte(QUOTE_BYTE);
                    end
                end else begin
                    push_byte(plain_byte(d));
                    push_body(d);
                end
                if (i != n_args - 1 || $urandom_range(0, 3) == 0) begin
                    push_byte(d);
                end
            end
        end
        push_line_end();
    endtask

    // Hold until every request has gone in and every result has come out,
    // then let the pipeline settle.
    task automatic drain();
        while (byte_requests.size() != 0 || s_valid || predicted_splits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_DELIMITER) begin
            delim_cfg = value;
        end else begin
            max_args_cfg = value[4:0];
        end
    endtask

    // One random phase: wait for earlier results, reprogram while idle, then
    // queue lines. The wait also makes the sender pause on an empty block.
    task automatic run_phase(input logic [7:0] d, input logic [7:0] max_args,
                             input int tx_pct, input int rx_pct, input int n_bytes);
        drain();
        write_reg(REG_DELIMITER, d);
        write_reg(REG_MAX_ARGS, max_args);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        phase_bytes  = 0;
        while (phase_bytes < n_bytes) begin
            push_line(d);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines under the reset configuration.
        tx_idle_pct  = 30;
        rx_stall_pct = 69;
        // ab,"c\"d",e\,f\x : plain, quoted with escaped quote, escaped
        // delimiter, dropped escape, argument closed by the line end
        push_byte("a");
        push_byte("b");
        push_byte(",");
        push_byte(QUOTE_BYTE);
        push_byte("c");
        push_byte(ESCAPE_BYTE);
        push_byte(QUOTE_BYTE);
        push_byte("d");
        push_byte(QUOTE_BYTE);
        push_byte(",");
        push_byte("e");
        push_byte(ESCAPE_BYTE);
        push_byte(",");
        push_byte("f");
        push_byte(ESCAPE_BYTE);
        push_byte("x");
        push_line_end();
        // Leading delimiter, argument opened by an escaped backslash, a zero
        // byte inside the line, the all-ones byte
        push_byte(",");
        push_byte(ESCAPE_BYTE);
        push_byte(ESCAPE_BYTE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_line_end();
        // Empty line
        push_line_end();

        run_phase(8'h20, 8'd16, 30, 69, 10);
        run_phase(8'h00, 8'd1, 30, 69, 10);

        // Backslash as delimiter, plus one quoted argument long enough to
        // fill the line buffer.
        run_phase(ESCAPE_BYTE, 8'd16, 69, 30, 10);
        push_byte(QUOTE_BYTE);
        repeat (LINE_SIZE + 6) push_byte(plain_byte(ESCAPE_BYTE));
        push_byte(QUOTE_BYTE);
        push_line_end();

        // Zero limit: every byte is ignored; only line ends still write the final zero.
        run_phase(8'hFF, 8'd0, 69, 30, 10);
        // Quote as delimiter: quoted arguments cannot open.
        run_phase(QUOTE_BYTE, 8'd5, 69, 30, 10);
        run_phase(8'($urandom_range(0, 255)), 8'd16, 0, 0, 20);
        run_phase(DELIM_RESET, 8'd3, 0, 0, 10);

        drain();
        if (bad_results == 0 && predicted_splits.size() == 0) begin
            $display("quoted_argument_splitter regression: pass");
        end else begin
            $display("quoted_argument_splitter regression: fail");
        end
        $finish;
    end

endmodule

FILE: quoted_argument_splitter.f
hw/rtl/qas_pkg.sv
hw/rtl/qas_step.sv
hw/rtl/quoted_argument_splitter.sv
bench/quoted_argument_splitter_test.sv
